@@ hdl/neel_anisotropy_field_energy_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Neel anisotropy field and energy unit
// Short wrappers that clock every property on clk_i and mute it in reset.
// ----------------------------------------------------------------------------
`ifndef NEEL_ANISOTROPY_FIELD_ENERGY_TOP_DEFINES_SVH
`define NEEL_ANISOTROPY_FIELD_ENERGY_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define NAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When pre holds at one edge, post must hold at the next one.
`define NAF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/naf_pkg.sv @@
// ----------------------------------------------------------------------------
// Neel anisotropy field and energy package
// Widths, state and product tag types, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package naf_pkg;

  localparam int SpinW     = 16;
  localparam int CoefW     = 32;
  localparam int FieldW    = 32;
  localparam int AtomW     = 8;
  localparam int WordW     = 7;
  localparam int AddrFullW = AtomW + WordW;
  localparam int AccW      = 48;
  localparam int MulAW     = 34;
  localparam int MulBW     = 32;
  localparam int ProdW     = MulAW + MulBW;
  localparam int TermW     = ProdW - 28;
  localparam int M3W       = 32;
  localparam int M4W       = 34;
  localparam int InDataW   = 192;
  localparam int OutDataW  = 128;

  localparam int WordsPerAtom = 91;
  localparam int LastT2Word   = 8;
  localparam int LastT4Word   = 89;
  localparam int ConstWord    = 90;
  localparam int MaxAtoms     = 256;

  localparam logic [1:0] LastAxis = 2'd2;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic signed [ProdW-1:0] Half14 = {{(ProdW-14){1'b0}}, 1'b1, {13{1'b0}}};
  localparam logic signed [ProdW-1:0] Half28 = {{(ProdW-28){1'b0}}, 1'b1, {27{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_AB2, ST_F2, ST_E2, ST_AB, ST_KD, ST_P3, ST_M4, ST_TM3, ST_TM4,
    ST_CONST, ST_FIN
  } st_e;

  // What the product register holds, and so how it is consumed next cycle.
  typedef enum logic [2:0] {
    TAG_NONE, TAG_QAB, TAG_QKD, TAG_P3, TAG_M4, TAG_FIELD2, TAG_FIELD4, TAG_ENERGY
  } tag_e;

  typedef struct packed {
    logic [FieldW-1:0] value;
    logic              clip;
  } sat_t;

  function automatic sat_t saturate(input logic signed [AccW-1:0] v);
    sat_t r;
    if (&v[AccW-1:FieldW-1] || ~|v[AccW-1:FieldW-1]) begin
      r.value = v[FieldW-1:0];
      r.clip  = 1'b0;
    end else if (v[AccW-1]) begin
      r.value = {1'b1, {(FieldW-1){1'b0}}};
      r.clip  = 1'b1;
    end else begin
      r.value = {1'b0, {(FieldW-1){1'b1}}};
      r.clip  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [SpinW-1:0] pick_spin(input logic [1:0] idx,
      input logic signed [SpinW-1:0] x, input logic signed [SpinW-1:0] y,
      input logic signed [SpinW-1:0] z);
    logic signed [SpinW-1:0] r;
    unique case (idx)
      2'd0:    r = x;
      2'd1:    r = y;
      default: r = z;
    endcase
    return r;
  endfunction

  // Round half up, then drop the fraction bits.
  function automatic logic signed [TermW-1:0] round_term(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p + Half28;
    return s[ProdW-1:28];
  endfunction

  function automatic logic signed [M3W-1:0] round_m3(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p + Half14;
    return s[M3W+13:14];
  endfunction

  function automatic logic signed [M4W-1:0] round_m4(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p + Half28;
    return s[M4W+27:28];
  endfunction

endpackage

@@ hdl/neel_anisotropy_field_energy_top.sv @@
// ----------------------------------------------------------------------------
// Neel anisotropy field and energy unit
// Per-atom coefficient store plus one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  coefficient write or compute request
//  m_axis    out        m_axis_tvalid / m_axis_tready  updated field, energy, clip flag
//  cfg       in         cfg_we_i                       enable bit
//
// A write request leaves the block idle, so the next request may follow at once.
// An enabled compute request keeps the block busy once accepted: each rank-2
// word runs AB2, F2 and E2, each rank-4 word KD, P3, M4, TM3 and TM4, with AB
// in front per (a, b) pair, then come the constant read and the output load,
// all set by the single 34x32 multiplier. A disabled request skips to FIN.
// Reset is asynchronous and active low; it clears the enable and all control
// state. The coefficient store is not cleared and must be written before use.
// A finished result waits in the output register; the sequencer stalls in its
// last step only when that register is still full and not being taken.
// ----------------------------------------------------------------------------
`include "neel_anisotropy_field_energy_top_defines.svh"

module neel_anisotropy_field_energy_top #(
  parameter int ATOM_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Enable register write port.
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // atom[7:0], word_index[14:8], word_value[46:15], spin_x[62:47], spin_y[78:63],
  // spin_z[94:79], field_in_x[126:95], field_in_y[158:127], field_in_z[190:159]
  input  logic [naf_pkg::InDataW-1:0]   s_axis_tdata,
  // action[0]
  input  logic                          s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // field_out_x[31:0], field_out_y[63:32], field_out_z[95:64], energy[127:96]
  output logic [naf_pkg::OutDataW-1:0]  m_axis_tdata,
  // saturated[0]
  output logic                          m_axis_tuser
);

  import naf_pkg::*;

  // Only atoms that an 8-bit index can reach get storage.
  localparam int NumAtoms = (ATOM_COUNT < MaxAtoms) ? ATOM_COUNT : MaxAtoms;
  localparam int RamDepth = NumAtoms * WordsPerAtom;
  localparam int RamAw    = $clog2(RamDepth);

  // Request fields.
  logic        [AtomW-1:0]  in_atom;
  logic        [WordW-1:0]  in_widx;
  logic signed [CoefW-1:0]  in_wval;
  logic signed [SpinW-1:0]  in_sx, in_sy, in_sz;
  logic signed [FieldW-1:0] in_hx, in_hy, in_hz;

  assign in_atom = s_axis_tdata[7:0];
  assign in_widx = s_axis_tdata[14:8];
  assign in_wval = s_axis_tdata[46:15];
  assign in_sx   = s_axis_tdata[62:47];
  assign in_sy   = s_axis_tdata[78:63];
  assign in_sz   = s_axis_tdata[94:79];
  assign in_hx   = s_axis_tdata[126:95];
  assign in_hy   = s_axis_tdata[158:127];
  assign in_hz   = s_axis_tdata[190:159];

  // Control state.
  st_e              state_q, state_d;
  tag_e             tag_q, tag_d;
  logic             en_q;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] word_q, word_d;
  logic [1:0]       a_q, a_d, b_q, b_d, k_q, k_d, d_q, d_d;
  logic [1:0]       tag_a_q, tag_a_d;

  // Datapath state.
  logic                        bypass_q, atom_ok_q;
  logic [AddrFullW-1:0]        base_q;
  logic signed [SpinW-1:0]     spin_x_q, spin_y_q, spin_z_q;
  logic signed [AccW-1:0]      acc_f_q [3];
  logic signed [AccW-1:0]      acc_f_d [3];
  logic signed [AccW-1:0]      acc_e_q, acc_e_d;
  logic signed [ProdW-1:0]     prod_q, prod_d;
  logic signed [31:0]          q_ab_q, q_ab_d, q_kd_q, q_kd_d;
  logic signed [M3W-1:0]       m3_q, m3_d;
  logic signed [M4W-1:0]       m4_q, m4_d;
  logic [OutDataW-1:0]         out_data_q, out_data_d;
  logic                        out_sat_q, out_sat_d;

  // Handshake decode.
  logic in_fire, wr_fire, cmp_fire, in_atom_ok, wr_ok;
  logic issue_rd, load_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign wr_fire    = in_fire && (s_axis_tuser == ACT_WRITE);
  assign cmp_fire   = in_fire && (s_axis_tuser == ACT_COMPUTE);
  assign in_atom_ok = int'(in_atom) < ATOM_COUNT;
  assign wr_ok      = wr_fire && in_atom_ok && (int'(in_widx) < WordsPerAtom);

  // Coefficient store. Writes happen in the accept cycle, reads only while a
  // computation runs, so the single port is never contended.
  logic                 ram_en, ram_we;
  logic [RamAw-1:0]     ram_addr;
  logic [CoefW-1:0]     ram_rdata;
  logic [AddrFullW-1:0] in_base, wr_addr_full, rd_addr_full;
  logic signed [CoefW-1:0] coef;

  assign in_base      = AddrFullW'(in_atom) * AddrFullW'(WordsPerAtom);
  assign wr_addr_full = in_base + AddrFullW'(in_widx);
  assign rd_addr_full = base_q + AddrFullW'(word_q);
  assign ram_en       = wr_ok || (issue_rd && atom_ok_q);
  assign ram_we       = wr_ok;
  assign ram_addr     = wr_ok ? wr_addr_full[RamAw-1:0] : rd_addr_full[RamAw-1:0];
  // An atom beyond the store behaves as if all its coefficients were zero.
  assign coef         = atom_ok_q ? signed'(ram_rdata) : '0;

  naf_ram #(
    .WIDTH (CoefW),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_wval),
    .rdata_o (ram_rdata)
  );

  // Spin components picked by the current tensor indices.
  logic signed [SpinW-1:0] s_a, s_b, s_k, s_d;
  logic signed [29:0]      m1;

  assign s_a = pick_spin(a_q, spin_x_q, spin_y_q, spin_z_q);
  assign s_b = pick_spin(b_q, spin_x_q, spin_y_q, spin_z_q);
  assign s_k = pick_spin(k_q, spin_x_q, spin_y_q, spin_z_q);
  assign s_d = pick_spin(d_q, spin_x_q, spin_y_q, spin_z_q);
  assign m1  = {s_b, 14'b0};

  // The one shared multiplier. Its product is registered and consumed in
  // the following cycle according to the tag that travels with it.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  assign prod_d = mul_a * mul_b;

  // Final energy and saturation.
  logic signed [AccW-1:0]  term_ext, e_neg, e_half, e_tot;
  sat_t                    fx_s, fy_s, fz_s, e_s;

  assign term_ext = AccW'(round_term(prod_q));
  assign e_neg    = AccW'(1) - acc_e_q;
  assign e_half   = e_neg >>> 1;
  assign e_tot    = bypass_q ? '0 : (e_half + AccW'(coef));
  assign fx_s     = saturate(acc_f_q[0]);
  assign fy_s     = saturate(acc_f_q[1]);
  assign fz_s     = saturate(acc_f_q[2]);
  assign e_s      = saturate(e_tot);

  // Product consumer: folds the previous cycle's product into its target.
  always_comb begin
    q_ab_d  = q_ab_q;
    q_kd_d  = q_kd_q;
    m3_d    = m3_q;
    m4_d    = m4_q;
    acc_e_d = acc_e_q;
    for (int i = 0; i < 3; i++) begin
      acc_f_d[i] = acc_f_q[i];
    end
    unique case (tag_q)
      TAG_QAB:    q_ab_d = prod_q[31:0];
      TAG_QKD:    q_kd_d = prod_q[31:0];
      TAG_P3:     m3_d   = round_m3(prod_q);
      TAG_M4:     m4_d   = round_m4(prod_q);
      TAG_ENERGY: acc_e_d = acc_e_q + term_ext;
      TAG_FIELD2: begin
        for (int i = 0; i < 3; i++) begin
          if (tag_a_q == 2'(i)) acc_f_d[i] = acc_f_q[i] + term_ext;
        end
      end
      TAG_FIELD4: begin
        // The rank-4 field term counts twice.
        for (int i = 0; i < 3; i++) begin
          if (tag_a_q == 2'(i)) acc_f_d[i] = acc_f_q[i] + (term_ext <<< 1);
        end
      end
      default: ;
    endcase
    // A new compute request starts from the incoming field.
    if (cmp_fire) begin
      acc_f_d[0] = AccW'(in_hx);
      acc_f_d[1] = AccW'(in_hy);
      acc_f_d[2] = AccW'(in_hz);
      acc_e_d    = '0;
    end
  end

  // Sequencer. Rank-2 words take AB2, F2, E2. Rank-4 words take KD, P3, M4,
  // TM3, TM4, with AB in front whenever the (a, b) pair changes.
  always_comb begin
    state_d  = state_q;
    tag_d    = TAG_NONE;
    tag_a_d  = a_q;
    mul_a    = '0;
    mul_b    = '0;
    issue_rd = 1'b0;
    load_out = 1'b0;
    word_d   = word_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    d_d      = d_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmp_fire) begin
          word_d  = '0;
          a_d     = '0;
          b_d     = '0;
          k_d     = '0;
          d_d     = '0;
          state_d = en_q ? ST_AB2 : ST_FIN;
        end
      end
      ST_AB2: begin
        issue_rd = 1'b1;
        mul_a    = MulAW'(s_a);
        mul_b    = MulBW'(s_b);
        tag_d    = TAG_QAB;
        state_d  = ST_F2;
      end
      ST_F2: begin
        mul_a   = MulAW'(m1);
        mul_b   = coef;
        tag_d   = TAG_FIELD2;
        state_d = ST_E2;
      end
      ST_E2: begin
        mul_a  = MulAW'(q_ab_q);
        mul_b  = coef;
        tag_d  = TAG_ENERGY;
        word_d = word_q + WordW'(1);
        if (word_q == WordW'(LastT2Word)) begin
          a_d     = '0;
          b_d     = '0;
          state_d = ST_AB;
        end else begin
          if (b_q == LastAxis) begin
            b_d = '0;
            a_d = a_q + 2'd1;
          end else begin
            b_d = b_q + 2'd1;
          end
          state_d = ST_AB2;
        end
      end
      ST_AB: begin
        mul_a   = MulAW'(s_a);
        mul_b   = MulBW'(s_b);
        tag_d   = TAG_QAB;
        state_d = ST_KD;
      end
      ST_KD: begin
        issue_rd = 1'b1;
        mul_a    = MulAW'(s_k);
        mul_b    = MulBW'(s_d);
        tag_d    = TAG_QKD;
        state_d  = ST_P3;
      end
      ST_P3: begin
        // s_k * s_d is still in the product register.
        mul_a   = MulAW'(signed'(prod_q[31:0]));
        mul_b   = MulBW'(s_b);
        tag_d   = TAG_P3;
        state_d = ST_M4;
      end
      ST_M4: begin
        mul_a   = MulAW'(q_ab_q);
        mul_b   = q_kd_q;
        tag_d   = TAG_M4;
        state_d = ST_TM3;
      end
      ST_TM3: begin
        mul_a   = MulAW'(m3_q);
        mul_b   = coef;
        tag_d   = TAG_FIELD4;
        state_d = ST_TM4;
      end
      ST_TM4: begin
        mul_a  = m4_q;
        mul_b  = coef;
        tag_d  = TAG_ENERGY;
        word_d = word_q + WordW'(1);
        if (word_q == WordW'(LastT4Word)) begin
          state_d = ST_CONST;
        end else if (d_q == LastAxis) begin
          d_d = '0;
          if (k_q == LastAxis) begin
            k_d = '0;
            if (b_q == LastAxis) begin
              b_d = '0;
              a_d = a_q + 2'd1;
            end else begin
              b_d = b_q + 2'd1;
            end
            state_d = ST_AB;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_KD;
          end
        end else begin
          d_d     = d_q + 2'd1;
          state_d = ST_KD;
        end
      end
      ST_CONST: begin
        issue_rd = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_data_d  = out_data_q;
    out_sat_d   = out_sat_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (load_out) begin
      out_data_d  = {e_s.value, fz_s.value, fy_s.value, fx_s.value};
      out_sat_d   = fx_s.clip | fy_s.clip | fz_s.clip | e_s.clip;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_q       <= TAG_NONE;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      d_q         <= '0;
      tag_a_q     <= '0;
    end else begin
      state_q     <= state_d;
      tag_q       <= tag_d;
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      a_q         <= a_d;
      b_q         <= b_d;
      k_q         <= k_d;
      d_q         <= d_d;
      tag_a_q     <= tag_a_d;
      if (cfg_we_i) en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_fire) begin
      bypass_q  <= !en_q;
      atom_ok_q <= in_atom_ok;
      base_q    <= in_base;
      spin_x_q  <= in_sx;
      spin_y_q  <= in_sy;
      spin_z_q  <= in_sz;
    end
    for (int i = 0; i < 3; i++) begin
      acc_f_q[i] <= acc_f_d[i];
    end
    acc_e_q    <= acc_e_d;
    prod_q     <= prod_d;
    q_ab_q     <= q_ab_d;
    q_kd_q     <= q_kd_d;
    m3_q       <= m3_d;
    m4_q       <= m4_d;
    out_data_q <= out_data_d;
    out_sat_q  <= out_sat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // The store port belongs to the sequencer while a computation runs.
  `NAF_ASSERT(a_no_write_busy, (state_q != ST_IDLE) |-> !ram_we, "store written while busy")
  // The rank-3 spin product must be waiting when M4 rounds it.
  `NAF_ASSERT(a_m4_after_p3, (state_q == ST_M4) |-> (tag_q == TAG_P3), "M4 without P3 product")
  // The energy constant is read from its own word.
  `NAF_ASSERT(a_const_word, (state_q == ST_CONST) |-> (word_q == WordW'(ConstWord)),
              "constant read at wrong word")
  // A result only appears out of the final step.
  `NAF_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN),
              "result loaded outside final step")
  // A disabled compute request goes straight to the final step.
  `NAF_ASSERT_NEXT(a_bypass_fast, cmp_fire && !en_q, state_q == ST_FIN,
                   "disabled request did not bypass")

endmodule

@@ hdl/naf_ram.sv @@
// ----------------------------------------------------------------------------
// Single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module naf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 23296,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while the port is not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Neel anisotropy field and energy unit
// Streams coefficient writes and compute requests into the block with random
// gaps and back-pressure. Every result is checked against a local fixed-point
// predictor of the anisotropy field and energy. The enable bit is switched
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import naf_pkg::*;

  localparam int ITEM_GOAL    = 950;
  localparam int STALL_LIMIT  = 4000;  // cycles without any handshake
  localparam int FLUSH_CYCLES = 460;   // one enabled compute plus a full stall
  localparam int MAX_READY    = 6;     // atoms fully loaded for computing

  // Request payload, packed exactly as s_axis_tdata expects it.
  typedef struct packed {
    logic               pad;
    logic signed [31:0] field_z;
    logic signed [31:0] field_y;
    logic signed [31:0] field_x;
    logic signed [15:0] spin_z;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_x;
    logic signed [31:0] word_value;
    logic [6:0]         word_index;
    logic [7:0]         atom;
  } req_fields_t;

  typedef struct packed {
    logic        action;
    req_fields_t f;
  } request_t;

  // Result layout: tuser on top, then tdata from energy down to field x.
  typedef struct packed {
    logic        clip;
    logic [31:0] energy;
    logic [31:0] field_z;
    logic [31:0] field_y;
    logic [31:0] field_x;
  } result_t;

  typedef enum int {COEF_WIDE, COEF_UNIT, COEF_TOP, COEF_BOTTOM, COEF_MIXED} coef_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  neel_anisotropy_field_energy_top #(
    .ATOM_COUNT(MaxAtoms)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor state: our own copy of the coefficient store and the enable bit.
  int   coef_mem [MaxAtoms][WordsPerAtom];
  logic coef_enable;

  // Stimulus bookkeeping. The planned map follows the request queue, so an
  // atom counts as ready once all of its words have been queued for writing;
  // computes on it are queued after those writes and never hit an empty word.
  logic [WordsPerAtom-1:0] planned_words [MaxAtoms];
  logic                    ready_flag [MaxAtoms];
  int                      ready_atoms[$];
  int                      item_total;

  request_t req_q[$];
  request_t req_cur;
  logic     req_busy;
  int       req_gap;
  logic     req_burst;

  result_t  field_exp_q[$];
  int       res_hold;
  logic     res_burst;

  int n_write, n_compute, n_results, n_clipped, n_phases, n_phases_off;
  int mismatch_cnt;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Add half an LSB of the target, then floor; >>> on a signed longint floors.
  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Clip flag in the top bit, the saturated 32-bit value below it.
  function automatic logic [32:0] clip32(longint v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Field update and site energy for one compute request. Spin monomials are
  // carried in Q.28, every coefficient product is rounded to Q.24 on its own,
  // and the quartic part counts twice in the field.
  function automatic result_t predict_field_energy(req_fields_t q);
    longint     s[3];
    longint     fld[3];
    longint     c[WordsPerAtom];
    longint     quad_e, quart_e, nrg, q2, q4, p3, m3, m4, t4;
    logic [32:0] sx, sy, sz, se;
    result_t    r;
    s[0]    = q.spin_x;
    s[1]    = q.spin_y;
    s[2]    = q.spin_z;
    fld[0]  = q.field_x;
    fld[1]  = q.field_y;
    fld[2]  = q.field_z;
    quad_e  = 0;
    quart_e = 0;
    nrg     = 0;
    if (coef_enable) begin
      for (int k = 0; k < WordsPerAtom; k++) c[k] = coef_mem[q.atom][k];
      for (int a = 0; a < 3; a++) begin
        q2 = 0;
        q4 = 0;
        for (int b = 0; b < 3; b++) begin
          q2     += round_q(c[3 * a + b] * (s[b] * 16384), 28);
          quad_e += round_q(c[3 * a + b] * (s[a] * s[b]), 28);
          for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < 3; d++) begin
              t4       = c[LastT2Word + 1 + 27 * a + 9 * b + 3 * k + d];
              p3       = s[b] * s[k] * s[d];
              m3       = round_q(p3, 14);
              m4       = round_q(p3 * s[a], 28);
              q4      += round_q(t4 * m3, 28);
              quart_e += round_q(t4 * m4, 28);
            end
          end
        end
        fld[a] = fld[a] + q2 + 2 * q4;
      end
      nrg = round_q(-(quad_e + quart_e), 1) + c[ConstWord];
    end
    sx        = clip32(fld[0]);
    sy        = clip32(fld[1]);
    sz        = clip32(fld[2]);
    se        = clip32(nrg);
    r.field_x = sx[31:0];
    r.field_y = sy[31:0];
    r.field_z = sz[31:0];
    r.energy  = se[31:0];
    r.clip    = sx[32] | sy[32] | sz[32] | se[32];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [31:0] coef_draw(coef_mode_e m);
    case (m)
      COEF_UNIT:   return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      COEF_TOP:    return 32'h7FFF_FFFF;
      COEF_BOTTOM: return 32'h8000_0000;
      COEF_MIXED: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0;
          default: return $urandom();
        endcase
      end
      default:     return $urandom();
    endcase
  endfunction

  // Spin kinds: 0 any pattern, 1 within plus or minus one, 2 corner values.
  function automatic logic [15:0] spin_draw(int kind);
    logic [31:0] v;
    if (kind == 0) return 16'($urandom());
    if (kind == 1) begin
      v = $urandom_range(0, 32768) - 16384;
      return v[15:0];
    end
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  // Field kinds: 0 any pattern, 1 modest magnitude, 2 corner values.
  function automatic logic [31:0] field_draw(int kind);
    if (kind == 0) return $urandom();
    if (kind == 1) return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Unused fields carry random bits so that every input bit but the pad toggles.
  function automatic req_fields_t noise_fields();
    req_fields_t f;
    f     = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    f.pad = 1'b0;
    return f;
  endfunction

  task automatic push_write(int a, int w, logic [31:0] v);
    request_t r;
    r.action       = ACT_WRITE;
    r.f            = noise_fields();
    r.f.atom       = a[7:0];
    r.f.word_index = w[6:0];
    r.f.word_value = v;
    req_q.push_back(r);
    // Writes beyond the constant word are dropped by the block; they are
    // noise and do not count toward the item goal.
    if (w < WordsPerAtom) begin
      item_total++;
      planned_words[a][w] = 1'b1;
      if (&planned_words[a] && !ready_flag[a]) begin
        ready_flag[a] = 1'b1;
        ready_atoms.push_back(a);
      end
    end
  endtask

  task automatic push_compute(int a, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                              logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    request_t r;
    r.action    = ACT_COMPUTE;
    r.f         = noise_fields();
    r.f.atom    = a[7:0];
    r.f.spin_x  = sx;
    r.f.spin_y  = sy;
    r.f.spin_z  = sz;
    r.f.field_x = hx;
    r.f.field_y = hy;
    r.f.field_z = hz;
    req_q.push_back(r);
    item_total++;
  endtask

  task automatic push_random_compute(int a);
    int sk;
    int fk;
    sk = $urandom_range(0, 2);
    fk = $urandom_range(0, 2);
    push_compute(a, spin_draw(sk), spin_draw(sk), spin_draw(sk),
                 field_draw(fk), field_draw(fk), field_draw(fk));
  endtask

  // All 91 words of one atom, in shuffled order.
  task automatic load_atom(int a, coef_mode_e m);
    int order[WordsPerAtom];
    int j;
    int tmp;
    for (int i = 0; i < WordsPerAtom; i++) order[i] = i;
    for (int i = WordsPerAtom - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < WordsPerAtom; i++) push_write(a, order[i], coef_draw(m));
  endtask

  function automatic int pick_ready();
    return ready_atoms[$urandom_range(0, ready_atoms.size() - 1)];
  endfunction

  // Blocks until every queued request went in and every result came out,
  // then lets as many more cycles pass as extra asks for.
  task automatic wait_quiet(int extra);
    while (req_q.size() != 0 || req_busy || field_exp_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // The enable bit is only changed with the block idle.
  task automatic set_enable(logic v);
    wait_quiet(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    coef_enable  = v;
    n_phases++;
    if (!v) n_phases_off++;
  endtask

  task automatic check_word(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("tb_top: %s mismatch on result %0d: expected %h, got %h",
                 what, n_results, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: takes the next request at the falling edge once the
  // drawn gap has run out, and holds it until the block accepts it.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (req_q.size() > 0) begin
          req_cur  = req_q.pop_front();
          req_busy = 1'b1;
        end
      end
      s_axis_tvalid <= req_busy;
      s_axis_tdata  <= req_cur.f;
      s_axis_tuser  <= req_cur.action;
    end
  end

  // Accepted requests update the predictor store or queue an expected result.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (req_cur.action == ACT_COMPUTE) begin
        field_exp_q.push_back(predict_field_energy(req_cur.f));
        n_compute++;
      end else begin
        if (int'(req_cur.f.word_index) < WordsPerAtom)
          coef_mem[req_cur.f.atom][req_cur.f.word_index] = req_cur.f.word_value;
        n_write++;
      end
      req_busy = 1'b0;
      req_gap  = req_burst ? 0 : $urandom_range(0, 17);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest expected
  // one, then draws how long the receiver stalls before the next.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = {m_axis_tuser, m_axis_tdata};
      if (field_exp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("tb_top: result %0d arrived with no compute request waiting: %h",
                   n_results, got);
      end else begin
        want = field_exp_q.pop_front();
        check_word("field x", want.field_x, got.field_x);
        check_word("field y", want.field_y, got.field_y);
        check_word("field z", want.field_z, got.field_z);
        check_word("energy", want.energy, got.energy);
        check_word("saturated", 32'(want.clip), 32'(got.clip));
      end
      if (got.clip) n_clipped++;
      res_hold = res_burst ? 0 : $urandom_range(0, 17);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_hold > 0) begin
        res_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: an enabled compute plus the longest stalls stays far below this.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int   phase_no;
    int   n_items;
    int   pick;
    int   a;
    logic en;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    coef_enable   = 1'b0;
    req_cur       = '0;
    req_busy      = 1'b0;
    req_gap       = 0;
    req_burst     = 1'b0;
    res_hold      = 0;
    res_burst     = 1'b0;
    item_total    = 0;
    n_write       = 0;
    n_compute     = 0;
    n_results     = 0;
    n_clipped     = 0;
    n_phases      = 1;
    n_phases_off  = 1;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    for (int i = 0; i < MaxAtoms; i++) begin
      planned_words[i] = '0;
      ready_flag[i]    = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the unit still disabled after reset: the field
    // must pass through untouched and the energy read zero, whatever the atom
    // or the store holds. Writes above the constant word must be dropped.
    push_compute(0, 16'h7FFF, 16'h8000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_compute(255, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000);
    push_compute(128, 16'h4000, 16'hC000, 16'hFFFF, 32'h0, 32'h0, 32'h0);
    push_random_compute($urandom_range(0, 255));
    push_random_compute($urandom_range(0, 255));
    push_write(7, ConstWord + 1, 32'h7FFF_FFFF);
    push_write(7, 127, 32'h8000_0000);
    push_write($urandom_range(0, 255), $urandom_range(ConstWord + 1, 127), $urandom());
    push_write(255, 0, 32'h7FFF_FFFF);
    push_write(0, ConstWord, 32'h8000_0000);
    push_write(255, LastT4Word, 32'h8000_0000);

    // Random phases. Every third phase runs with the unit disabled; the rest
    // mostly compute on fully loaded atoms, with word rewrites, partial loads
    // of other atoms and dropped writes mixed in.
    phase_no = 0;
    while (item_total < ITEM_GOAL) begin
      en = (phase_no % 3 == 2) ? 1'b0 : 1'b1;
      set_enable(en);
      phase_no++;
      req_burst = ($urandom_range(0, 3) == 0);
      res_burst = ($urandom_range(0, 3) == 0);

      if (phase_no == 1) begin
        // Saturation corners: all coefficients at the top and at the bottom
        // of their range, driven with corner spins and fields.
        load_atom(255, COEF_TOP);
        repeat (4) push_compute(255, spin_draw(2), spin_draw(2), spin_draw(2),
                                field_draw(2), field_draw(2), field_draw(2));
        load_atom(0, COEF_BOTTOM);
        repeat (4) push_compute(0, spin_draw(2), spin_draw(2), spin_draw(2),
                                field_draw(2), field_draw(2), field_draw(2));
      end else if (ready_atoms.size() < MAX_READY && $urandom_range(0, 2) == 0) begin
        do a = $urandom_range(0, 255); while (ready_flag[a]);
        load_atom(a, coef_mode_e'($urandom_range(0, 4)));
      end

      n_items = $urandom_range(15, 35);
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // A disabled compute reads no coefficient, so any atom will do.
          push_random_compute(en ? pick_ready() : $urandom_range(0, 255));
        end else if (pick < 82) begin
          push_write(pick_ready(), $urandom_range(0, ConstWord),
                     coef_draw(coef_mode_e'($urandom_range(0, 4))));
        end else if (pick < 92) begin
          push_write($urandom_range(0, 255), $urandom_range(0, ConstWord), $urandom());
        end else begin
          push_write($urandom_range(0, 255), $urandom_range(ConstWord + 1, 127), $urandom());
        end
      end
    end

    wait_quiet(FLUSH_CYCLES);
    $display("tb_top: %0d coefficient writes and %0d compute requests over %0d enable phases",
             n_write, n_compute, n_phases);
    $display("tb_top: %0d phases disabled, %0d results checked, %0d clipped, %0d mismatches",
             n_phases_off, n_results, n_clipped, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
